FILE: hw/rtl/plan_load_session_controller_assert.svh
// assertion macros for the plan load session controller
`ifndef PLAN_LOAD_SESSION_CONTROLLER_ASSERT_SVH
`define PLAN_LOAD_SESSION_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define PLSC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plsc assertion failed");
`define PLSC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plsc assertion failed");
`else
`define PLSC_ASSERT_IMP(lbl, ante, cons)
`define PLSC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/plsc_pkg.sv
// shared types, codes and helpers for the plan load session controller
`timescale 1ns / 1ps

package plsc_pkg;

	localparam logic [31:0] MAX_PLAN_LENGTH_RESET = 32'd1048576;
	localparam int unsigned PADDR_W = 3;
	localparam logic REG_MAX_PLAN_LENGTH = 1'b0;

	typedef enum logic [3:0] {
		MODE_FEED        = 4'd0,
		MODE_EOF         = 4'd1,
		MODE_HELLO       = 4'd2,
		MODE_BEGIN_HOP   = 4'd3,
		MODE_FINISH_HOP  = 4'd4,
		MODE_CANCEL      = 4'd5,
		MODE_BEGIN_KV    = 4'd6,
		MODE_FINISH_KV   = 4'd7,
		MODE_UNLOAD      = 4'd8,
		MODE_FIN_UNLOAD  = 4'd9
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_STATE      = 3'd1,
		ERR_TOO_LARGE  = 3'd2,
		ERR_EOF        = 3'd3,
		ERR_INCOMPLETE = 3'd4,
		ERR_BUSY       = 3'd5,
		ERR_NO_OP      = 3'd6,
		ERR_WRONG_OP   = 3'd7
	} err_t;

	localparam logic [2:0] CODE_AWAIT     = 3'd0;
	localparam logic [2:0] CODE_LOADED    = 3'd1;
	localparam logic [2:0] CODE_READY     = 3'd2;
	localparam logic [2:0] CODE_HOP       = 3'd3;
	localparam logic [2:0] CODE_KV        = 3'd4;
	localparam logic [2:0] CODE_UNLOADING = 3'd5;
	localparam logic [2:0] CODE_UNLOADED  = 3'd6;
	localparam logic [2:0] CODE_FAILED    = 3'd7;

	typedef enum logic [7:0] {
		S_AWAIT     = 8'b0000_0001,
		S_LOADED    = 8'b0000_0010,
		S_READY     = 8'b0000_0100,
		S_HOP       = 8'b0000_1000,
		S_KV        = 8'b0001_0000,
		S_UNLOADING = 8'b0010_0000,
		S_UNLOADED  = 8'b0100_0000,
		S_FAILED    = 8'b1000_0000
	} sess_t;

	localparam logic [3:0] KIND_HOP    = 4'd0;
	localparam logic [3:0] KIND_UNLOAD = 4'd8;

	typedef struct packed {
		logic [2:0] state_code;
		logic [2:0] error_code;
		logic [7:0] payload_byte;
		logic       payload_valid;
	} result_t;

	function automatic logic [2:0] sess_code(input sess_t s);
		logic [2:0] c;
		c = CODE_AWAIT;
		unique case (s)
			S_AWAIT:     c = CODE_AWAIT;
			S_LOADED:    c = CODE_LOADED;
			S_READY:     c = CODE_READY;
			S_HOP:       c = CODE_HOP;
			S_KV:        c = CODE_KV;
			S_UNLOADING: c = CODE_UNLOADING;
			S_UNLOADED:  c = CODE_UNLOADED;
			S_FAILED:    c = CODE_FAILED;
			default:     c = CODE_AWAIT;
		endcase
		return c;
	endfunction

	function automatic logic is_kv(input logic [3:0] k);
		return (k != 4'd0) && !k[3];
	endfunction

endpackage

FILE: hw/rtl/plsc_cfg.sv
// apb register holding the maximum plan length
`timescale 1ns / 1ps

module plsc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plsc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [31:0]                   max_plan_length
);

	logic [31:0] max_q;
	logic        hit;

	assign hit = (paddr[2] == plsc_pkg::REG_MAX_PLAN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= plsc_pkg::MAX_PLAN_LENGTH_RESET;
		end else if (psel && penable && pwrite && hit) begin
			max_q <= pwdata;
		end
	end

	assign prdata          = hit ? max_q : 32'd0;
	assign pready          = 1'b1;
	assign max_plan_length = max_q;

endmodule

FILE: hw/rtl/plsc_core.sv
// input register, plan reader and session state machine
`timescale 1ns / 1ps

module plsc_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          mode,
	input  logic [7:0]          data_byte,
	input  logic [3:0]          operation_code,
	input  logic [31:0]         max_plan_length,
	output logic                res_valid,
	input  logic                res_ready,
	output plsc_pkg::result_t   res
);

	plsc_pkg::mode_t mode_s1;
	logic [7:0]      byte_s1;
	logic [3:0]      op_s1;
	logic            valid_s1;

	logic [31:0]     len_q, len_n;
	logic [2:0]      pcnt_q, pcnt_n;
	logic            lknown_q, lknown_n;
	logic [31:0]     rcnt_q, rcnt_n;
	logic            rcomplete_q, rcomplete_n;
	logic            rfailed_q, rfailed_n;
	plsc_pkg::sess_t sess_q, sess_n;
	logic [3:0]      kind_q, kind_n;
	logic            active_q, active_n;

	logic            advance;
	logic            is_feed;
	logic [31:0]     len_cat;
	logic [31:0]     rcnt_inc;
	logic [2:0]      feed_state;
	plsc_pkg::err_t  err;
	logic [7:0]      pb;
	logic            pv;

	assign advance  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= plsc_pkg::mode_t'(mode);
			byte_s1 <= data_byte;
			op_s1   <= operation_code;
		end
	end

	assign len_cat  = len_q | ({24'd0, byte_s1} << {pcnt_q[1:0], 3'b000});
	assign rcnt_inc = rcnt_q + 32'd1;

	always_comb begin
		len_n       = len_q;
		pcnt_n      = pcnt_q;
		lknown_n    = lknown_q;
		rcnt_n      = rcnt_q;
		rcomplete_n = rcomplete_q;
		rfailed_n   = rfailed_q;
		sess_n      = sess_q;
		kind_n      = kind_q;
		active_n    = active_q;
		is_feed     = 1'b0;
		feed_state  = plsc_pkg::CODE_AWAIT;
		err         = plsc_pkg::ERR_NONE;
		pb          = 8'd0;
		pv          = 1'b0;
		unique case (mode_s1)
			plsc_pkg::MODE_FEED: begin
				is_feed = 1'b1;
				priority if (rfailed_q) begin
					err = plsc_pkg::ERR_STATE;
				end else if (rcomplete_q) begin
					feed_state = plsc_pkg::CODE_LOADED;
				end else if (!lknown_q) begin
					len_n  = len_cat;
					pcnt_n = pcnt_q + 3'd1;
					if (pcnt_q == 3'd3) begin
						lknown_n = 1'b1;
						priority if (len_cat > max_plan_length) begin
							rfailed_n = 1'b1;
							err       = plsc_pkg::ERR_TOO_LARGE;
						end else if (rcnt_q == len_cat) begin
							rcomplete_n = 1'b1;
							feed_state  = plsc_pkg::CODE_LOADED;
						end else begin
							feed_state = plsc_pkg::CODE_AWAIT;
						end
					end
				end else begin
					rcnt_n = rcnt_inc;
					pb     = byte_s1;
					pv     = 1'b1;
					if (rcnt_inc == len_q) begin
						rcomplete_n = 1'b1;
						feed_state  = plsc_pkg::CODE_LOADED;
					end
				end
			end
			plsc_pkg::MODE_EOF: begin
				if (sess_q != plsc_pkg::S_UNLOADED) begin
					if (!rcomplete_q) begin
						rfailed_n = 1'b1;
					end
					sess_n   = plsc_pkg::S_FAILED;
					active_n = 1'b0;
					err      = plsc_pkg::ERR_EOF;
				end
			end
			plsc_pkg::MODE_HELLO: begin
				if (sess_q != plsc_pkg::S_AWAIT || !rcomplete_q) begin
					err = plsc_pkg::ERR_STATE;
				end else begin
					sess_n = plsc_pkg::S_READY;
				end
			end
			plsc_pkg::MODE_BEGIN_HOP: begin
				priority if (active_q) begin
					err = plsc_pkg::ERR_BUSY;
				end else if (sess_q != plsc_pkg::S_READY) begin
					err = plsc_pkg::ERR_STATE;
				end else begin
					sess_n   = plsc_pkg::S_HOP;
					kind_n   = plsc_pkg::KIND_HOP;
					active_n = 1'b1;
				end
			end
			plsc_pkg::MODE_FINISH_HOP: begin
				priority if (!active_q) begin
					err = plsc_pkg::ERR_NO_OP;
				end else if (kind_q != plsc_pkg::KIND_HOP) begin
					err = plsc_pkg::ERR_WRONG_OP;
				end else begin
					active_n = 1'b0;
					sess_n   = plsc_pkg::S_READY;
				end
			end
			plsc_pkg::MODE_CANCEL: begin
				if (!active_q || kind_q != plsc_pkg::KIND_HOP) begin
					err = plsc_pkg::ERR_STATE;
				end else begin
					active_n = 1'b0;
					sess_n   = plsc_pkg::S_READY;
				end
			end
			plsc_pkg::MODE_BEGIN_KV: begin
				priority if (!plsc_pkg::is_kv(op_s1)) begin
					err = plsc_pkg::ERR_WRONG_OP;
				end else if (active_q) begin
					err = plsc_pkg::ERR_BUSY;
				end else if (sess_q != plsc_pkg::S_READY) begin
					err = plsc_pkg::ERR_STATE;
				end else begin
					kind_n   = op_s1;
					active_n = 1'b1;
					sess_n   = plsc_pkg::S_KV;
				end
			end
			plsc_pkg::MODE_FINISH_KV: begin
				priority if (!active_q) begin
					err = plsc_pkg::ERR_NO_OP;
				end else if (!plsc_pkg::is_kv(kind_q)) begin
					err = plsc_pkg::ERR_WRONG_OP;
				end else begin
					active_n = 1'b0;
					sess_n   = plsc_pkg::S_READY;
				end
			end
			plsc_pkg::MODE_UNLOAD: begin
				priority if (active_q) begin
					err = plsc_pkg::ERR_BUSY;
				end else if (sess_q != plsc_pkg::S_READY) begin
					err = plsc_pkg::ERR_STATE;
				end else begin
					kind_n   = plsc_pkg::KIND_UNLOAD;
					active_n = 1'b1;
					sess_n   = plsc_pkg::S_UNLOADING;
				end
			end
			plsc_pkg::MODE_FIN_UNLOAD: begin
				if (!active_q || kind_q != plsc_pkg::KIND_UNLOAD) begin
					err = plsc_pkg::ERR_WRONG_OP;
				end else begin
					active_n = 1'b0;
					sess_n   = plsc_pkg::S_UNLOADED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= 32'd0;
			pcnt_q      <= 3'd0;
			lknown_q    <= 1'b0;
			rcnt_q      <= 32'd0;
			rcomplete_q <= 1'b0;
			rfailed_q   <= 1'b0;
			sess_q      <= plsc_pkg::S_AWAIT;
			kind_q      <= 4'd0;
			active_q    <= 1'b0;
		end else if (advance) begin
			len_q       <= len_n;
			pcnt_q      <= pcnt_n;
			lknown_q    <= lknown_n;
			rcnt_q      <= rcnt_n;
			rcomplete_q <= rcomplete_n;
			rfailed_q   <= rfailed_n;
			sess_q      <= sess_n;
			kind_q      <= kind_n;
			active_q    <= active_n;
		end
	end

	assign res_valid          = valid_s1;
	assign res.state_code     = is_feed ? feed_state : plsc_pkg::sess_code(sess_n);
	assign res.error_code     = err;
	assign res.payload_byte   = pb;
	assign res.payload_valid  = pv;

endmodule

FILE: hw/rtl/plsc_out_buf.sv
// two-entry result register with skid entry
`timescale 1ns / 1ps

module plsc_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  plsc_pkg::result_t push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output plsc_pkg::result_t out_data
);

	plsc_pkg::result_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign out_valid  = (count_q != 2'd0);
	assign pop        = out_valid && out_ready;
	assign push_ready = (count_q != 2'd2) || out_ready;
	assign push       = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	assign out_data = entry_q[rd_ptr_q];

endmodule

FILE: hw/rtl/plan_load_session_controller.sv
// plan load session controller: plan byte reader and session state machine
//
// input channel: in_valid/in_ready with mode, data_byte, operation_code;
// each item is one event, a feed item carries one plan byte
// output channel: out_valid/out_ready with state_code, error_code,
// payload_byte, payload_valid; exactly one result per input item, in order
// config: apb write of max_plan_length at byte address 0, pready always high
// path: an accepted item is held in the input register, and its result is held in
// the result register, which drives out_valid
// throughput: one item per cycle while the result buffer can take a result
// stall: the result buffer holds two results and the input register one,
// so up to three items are taken while out_ready is low before in_ready drops
// reset: arst_n clears the plan reader, puts the session in awaiting plan,
// empties the buffers and loads max_plan_length with 1048576
// payload bytes leave with payload_valid set and are not stored here
`timescale 1ns / 1ps

module plan_load_session_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [3:0]                    mode,
	input  logic [7:0]                    data_byte,
	input  logic [3:0]                    operation_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    state_code,
	output logic [2:0]                    error_code,
	output logic [7:0]                    payload_byte,
	output logic                          payload_valid,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [plsc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	`include "plan_load_session_controller_assert.svh"

	logic [31:0]       max_plan_length;
	logic              res_valid;
	logic              res_ready;
	plsc_pkg::result_t res;
	plsc_pkg::result_t out_data;

	plsc_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.max_plan_length (max_plan_length)
	);

	plsc_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.data_byte       (data_byte),
		.operation_code  (operation_code),
		.max_plan_length (max_plan_length),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res)
	);

	plsc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (res_ready),
		.push_data  (res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	assign state_code    = out_data.state_code;
	assign error_code    = out_data.error_code;
	assign payload_byte  = out_data.payload_byte;
	assign payload_valid = out_data.payload_valid;

	`PLSC_ASSERT_IMP(a_payload_only_on_reader, out_valid && payload_valid, (state_code == plsc_pkg::CODE_AWAIT || state_code == plsc_pkg::CODE_LOADED) && error_code == plsc_pkg::ERR_NONE)
	`PLSC_ASSERT_IMP(a_stall_only_when_blocked, !in_ready, out_valid && !out_ready)
	`PLSC_ASSERT_NXT(a_cfg_write_lands, psel && penable && pwrite && pready && paddr[2] == plsc_pkg::REG_MAX_PLAN_LENGTH, max_plan_length == $past(pwdata))

endmodule

FILE: tb/sv/plan_load_session_checker.sv
// checker for the plan load session controller: predicts every result and compares
`timescale 1ns / 1ps

module plan_load_session_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [3:0]                   mode,
	input  logic [7:0]                   data_byte,
	input  logic [3:0]                   operation_code,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [2:0]                   state_code,
	input  logic [2:0]                   error_code,
	input  logic [7:0]                   payload_byte,
	input  logic                         payload_valid,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [plsc_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output int                           mismatch_count,
	output int                           results_owed
);

	localparam int unsigned AW = plsc_pkg::PADDR_W;
	localparam logic [AW-1:0] LIMIT_ADDR = AW'(4 * plsc_pkg::REG_MAX_PLAN_LENGTH);

	logic [31:0] plan_limit;
	logic [31:0] plan_len;
	logic [2:0]  pfx_count;
	logic        len_known;
	logic [31:0] bytes_counted;
	logic        plan_done;
	logic        reader_bad;
	logic [2:0]  sess;
	logic [3:0]  op_kind;
	logic        op_busy;

	plsc_pkg::result_t owed_results[$];
	plsc_pkg::result_t want;

	function automatic logic kv_kind(input logic [3:0] k);
		return (k > plsc_pkg::KIND_HOP) && (k < plsc_pkg::KIND_UNLOAD);
	endfunction

	function automatic plsc_pkg::result_t take_byte(input logic [7:0] b);
		plsc_pkg::result_t r;
		r = '0;
		r.state_code = plsc_pkg::CODE_AWAIT;
		if (reader_bad) begin
			r.error_code = plsc_pkg::ERR_STATE;
		end else if (plan_done) begin
			r.state_code = plsc_pkg::CODE_LOADED;
		end else if (!len_known) begin
			plan_len = plan_len | (32'(b) << (8 * pfx_count[1:0]));
			pfx_count = pfx_count + 3'd1;
			if (pfx_count == 3'd4) begin
				len_known = 1'b1;
				if (plan_len > plan_limit) begin
					reader_bad = 1'b1;
					r.error_code = plsc_pkg::ERR_TOO_LARGE;
				end else if (bytes_counted == plan_len) begin
					plan_done = 1'b1;
					r.state_code = plsc_pkg::CODE_LOADED;
				end
			end
		end else begin
			bytes_counted = bytes_counted + 32'd1;
			r.payload_byte = b;
			r.payload_valid = 1'b1;
			if (bytes_counted == plan_len) begin
				plan_done = 1'b1;
				r.state_code = plsc_pkg::CODE_LOADED;
			end
		end
		return r;
	endfunction

	function automatic plsc_pkg::result_t step_session(input logic [3:0] m,
			input logic [7:0] b, input logic [3:0] op);
		plsc_pkg::result_t r;
		plsc_pkg::err_t e;
		r = '0;
		e = plsc_pkg::ERR_NONE;
		case (m)
			plsc_pkg::MODE_FEED: begin
				return take_byte(b);
			end
			plsc_pkg::MODE_EOF: begin
				if (sess != plsc_pkg::CODE_UNLOADED) begin
					if (!plan_done)
						reader_bad = 1'b1;
					sess = plsc_pkg::CODE_FAILED;
					op_busy = 1'b0;
					e = plsc_pkg::ERR_EOF;
				end
			end
			plsc_pkg::MODE_HELLO: begin
				if (sess != plsc_pkg::CODE_AWAIT || !plan_done)
					e = plsc_pkg::ERR_STATE;
				else
					sess = plsc_pkg::CODE_READY;
			end
			plsc_pkg::MODE_BEGIN_HOP: begin
				if (op_busy) begin
					e = plsc_pkg::ERR_BUSY;
				end else if (sess != plsc_pkg::CODE_READY) begin
					e = plsc_pkg::ERR_STATE;
				end else begin
					sess = plsc_pkg::CODE_HOP;
					op_kind = plsc_pkg::KIND_HOP;
					op_busy = 1'b1;
				end
			end
			plsc_pkg::MODE_FINISH_HOP: begin
				if (!op_busy) begin
					e = plsc_pkg::ERR_NO_OP;
				end else if (op_kind != plsc_pkg::KIND_HOP) begin
					e = plsc_pkg::ERR_WRONG_OP;
				end else begin
					op_busy = 1'b0;
					sess = plsc_pkg::CODE_READY;
				end
			end
			plsc_pkg::MODE_CANCEL: begin
				if (!op_busy || op_kind != plsc_pkg::KIND_HOP) begin
					e = plsc_pkg::ERR_STATE;
				end else begin
					op_busy = 1'b0;
					sess = plsc_pkg::CODE_READY;
				end
			end
			plsc_pkg::MODE_BEGIN_KV: begin
				if (!kv_kind(op)) begin
					e = plsc_pkg::ERR_WRONG_OP;
				end else if (op_busy) begin
					e = plsc_pkg::ERR_BUSY;
				end else if (sess != plsc_pkg::CODE_READY) begin
					e = plsc_pkg::ERR_STATE;
				end else begin
					op_kind = op;
					op_busy = 1'b1;
					sess = plsc_pkg::CODE_KV;
				end
			end
			plsc_pkg::MODE_FINISH_KV: begin
				if (!op_busy) begin
					e = plsc_pkg::ERR_NO_OP;
				end else if (!kv_kind(op_kind)) begin
					e = plsc_pkg::ERR_WRONG_OP;
				end else begin
					op_busy = 1'b0;
					sess = plsc_pkg::CODE_READY;
				end
			end
			plsc_pkg::MODE_UNLOAD: begin
				if (op_busy) begin
					e = plsc_pkg::ERR_BUSY;
				end else if (sess != plsc_pkg::CODE_READY) begin
					e = plsc_pkg::ERR_STATE;
				end else begin
					op_kind = plsc_pkg::KIND_UNLOAD;
					op_busy = 1'b1;
					sess = plsc_pkg::CODE_UNLOADING;
				end
			end
			plsc_pkg::MODE_FIN_UNLOAD: begin
				if (!op_busy || op_kind != plsc_pkg::KIND_UNLOAD) begin
					e = plsc_pkg::ERR_WRONG_OP;
				end else begin
					op_busy = 1'b0;
					sess = plsc_pkg::CODE_UNLOADED;
				end
			end
			default: begin
			end
		endcase
		r.state_code = sess;
		r.error_code = e;
		return r;
	endfunction

	task automatic flag_field(input string field, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0d ns: %s expected %0d actual %0d", $time, field, want_v, got_v);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_limit = plsc_pkg::MAX_PLAN_LENGTH_RESET;
			plan_len = '0;
			pfx_count = '0;
			len_known = 1'b0;
			bytes_counted = '0;
			plan_done = 1'b0;
			reader_bad = 1'b0;
			sess = plsc_pkg::CODE_AWAIT;
			op_kind = plsc_pkg::KIND_HOP;
			op_busy = 1'b0;
			owed_results.delete();
			mismatch_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
				plan_limit = pwdata;
			if (in_valid && in_ready)
				owed_results.push_back(step_session(mode, data_byte, operation_code));
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$display("%0d ns: result with no item pending, state %0d error %0d",
						$time, state_code, error_code);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					flag_field("state_code", want.state_code, state_code);
					flag_field("error_code", want.error_code, error_code);
					flag_field("payload_byte", want.payload_byte, payload_byte);
					flag_field("payload_valid", want.payload_valid, payload_valid);
				end
			end
		end
		results_owed = owed_results.size();
	end

endmodule

FILE: tb/sv/tb_plan_load_session_controller.sv
// testbench top for the plan load session controller: stimulus, receiver and verdict
`timescale 1ns / 1ps

module tb_plan_load_session_controller;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int MODE_SPACE_TOP = 15;
	localparam int SHAPE_OVERSIZED = 0;
	localparam int SHAPE_EMPTY = 1;
	localparam int unsigned AW = plsc_pkg::PADDR_W;
	localparam logic [AW-1:0] LIMIT_ADDR = AW'(4 * plsc_pkg::REG_MAX_PLAN_LENGTH);

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         mode;
	logic [7:0]         data_byte;
	logic [3:0]         operation_code;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         state_code;
	logic [2:0]         error_code;
	logic [7:0]         payload_byte;
	logic               payload_valid;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [AW-1:0]      paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int mismatch_count;
	int results_owed;
	int items_sent;
	int cycle_count;
	int plan_shape;
	logic [31:0] plan_bytes;
	logic [31:0] plan_limit;
	bit send_gaps;
	bit recv_gaps;
	bit hold_output;
	bit hold_done;

	plan_load_session_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.data_byte(data_byte),
		.operation_code(operation_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.state_code(state_code),
		.error_code(error_code),
		.payload_byte(payload_byte),
		.payload_valid(payload_valid),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	plan_load_session_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.data_byte(data_byte),
		.operation_code(operation_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.state_code(state_code),
		.error_code(error_code),
		.payload_byte(payload_byte),
		.payload_valid(payload_valid),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic push_event(input logic [3:0] m, input logic [7:0] b, input logic [3:0] op);
		if (send_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= b;
		operation_code <= op;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic command(input logic [3:0] m);
		push_event(m, 8'($urandom), 4'($urandom));
	endtask

	task automatic kv_start(input logic [3:0] op);
		push_event(plsc_pkg::MODE_BEGIN_KV, 8'($urandom), op);
	endtask

	task automatic feed(input logic [7:0] b);
		push_event(plsc_pkg::MODE_FEED, b, 4'($urandom));
	endtask

	// any command except end of input, while the plan is still being read
	task automatic reader_stray();
		command(4'($urandom_range(int'(plsc_pkg::MODE_HELLO), MODE_SPACE_TOP)));
	endtask

	// any event that keeps the session alive
	task automatic session_stray();
		logic [3:0] m;
		m = 4'($urandom_range(0, MODE_SPACE_TOP));
		if (m == plsc_pkg::MODE_EOF || m == plsc_pkg::MODE_UNLOAD)
			m = plsc_pkg::MODE_FEED;
		command(m);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_plan_limit(input logic [31:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = plsc_pkg::MODE_FEED;
		data_byte = '0;
		operation_code = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycle_count = 0;
		items_sent = 0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		hold_output = 1'b0;
		hold_done = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// session commands with no plan yet
		command(plsc_pkg::MODE_HELLO);
		command(plsc_pkg::MODE_BEGIN_HOP);
		command(plsc_pkg::MODE_FINISH_HOP);
		command(plsc_pkg::MODE_CANCEL);
		kv_start(plsc_pkg::KIND_HOP);
		kv_start(plsc_pkg::KIND_UNLOAD);
		kv_start(4'hF);
		kv_start(plsc_pkg::KIND_HOP + 4'd3);
		command(plsc_pkg::MODE_FINISH_KV);
		command(plsc_pkg::MODE_UNLOAD);
		command(plsc_pkg::MODE_FIN_UNLOAD);
		command(4'(plsc_pkg::MODE_FIN_UNLOAD + 1));
		command(4'(MODE_SPACE_TOP));

		set_plan_limit('0);
		repeat (3) reader_stray();
		set_plan_limit('1);
		repeat (3) reader_stray();

		plan_shape = $urandom_range(0, 7);
		if (plan_shape == SHAPE_OVERSIZED) begin
			plan_limit = $urandom_range(0, 1) ? 32'hFFFF_FFFE : 32'($urandom_range(0, 200));
			plan_bytes = plan_limit + 32'd1;
		end else if (plan_shape == SHAPE_EMPTY) begin
			plan_limit = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
			plan_bytes = '0;
		end else begin
			plan_bytes = $urandom_range(40, 160);
			plan_limit = $urandom_range(0, 1) ? plan_bytes : '1;
		end
		set_plan_limit(plan_limit);
		send_gaps = $urandom_range(0, 1);

		// length prefix, low byte first
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(0, 5) == 0)
				reader_stray();
			feed(plan_bytes[8 * i +: 8]);
		end
		if (plan_shape != SHAPE_OVERSIZED) begin
			for (int i = 0; i < plan_bytes; i++) begin
				if ($urandom_range(0, 5) == 0)
					reader_stray();
				if (i == 0)
					feed(8'h00);
				else if (i == 1)
					feed(8'hFF);
				else
					feed(8'($urandom));
			end
		end
		// bytes beyond a finished or failed plan
		feed(8'h00);
		feed(8'hFF);
		feed(8'($urandom));

		send_gaps = 1'b1;
		command(plsc_pkg::MODE_HELLO);
		command(plsc_pkg::MODE_HELLO);
		command(plsc_pkg::MODE_BEGIN_HOP);
		command(plsc_pkg::MODE_BEGIN_HOP);
		kv_start(plsc_pkg::KIND_HOP + 4'd2);
		command(plsc_pkg::MODE_FINISH_KV);
		command(plsc_pkg::MODE_UNLOAD);
		command(plsc_pkg::MODE_FIN_UNLOAD);
		command(plsc_pkg::MODE_FINISH_HOP);
		command(plsc_pkg::MODE_FINISH_HOP);
		command(plsc_pkg::MODE_BEGIN_HOP);
		command(plsc_pkg::MODE_CANCEL);
		command(plsc_pkg::MODE_CANCEL);
		kv_start(plsc_pkg::KIND_HOP + 4'd1);
		command(plsc_pkg::MODE_FINISH_HOP);
		command(plsc_pkg::MODE_CANCEL);
		kv_start(plsc_pkg::KIND_UNLOAD - 4'd1);
		command(plsc_pkg::MODE_FINISH_KV);
		command(plsc_pkg::MODE_FINISH_KV);

		while (items_sent < 440) begin
			if (!hold_done && items_sent >= 200) begin
				hold_output = 1'b1;
				hold_done = 1'b1;
			end
			if ($urandom_range(0, 15) == 0) begin
				send_gaps = $urandom_range(0, 1);
				recv_gaps = $urandom_range(0, 1);
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					command(plsc_pkg::MODE_BEGIN_HOP);
					if ($urandom_range(0, 2) == 0)
						session_stray();
					if ($urandom_range(0, 1))
						command(plsc_pkg::MODE_FINISH_HOP);
					else
						command(plsc_pkg::MODE_CANCEL);
				end
				3, 4, 5: begin
					kv_start(4'($urandom_range(plsc_pkg::KIND_HOP + 1,
						plsc_pkg::KIND_UNLOAD - 1)));
					if ($urandom_range(0, 2) == 0)
						session_stray();
					command(plsc_pkg::MODE_FINISH_KV);
				end
				6: begin
					command(plsc_pkg::MODE_HELLO);
				end
				default: begin
					repeat ($urandom_range(1, 3)) session_stray();
				end
			endcase
		end

		// closing part runs without stalls
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		repeat (20) session_stray();
		command(plsc_pkg::MODE_FINISH_HOP);
		command(plsc_pkg::MODE_FINISH_KV);
		if ($urandom_range(0, 1)) begin
			command(plsc_pkg::MODE_UNLOAD);
			command(plsc_pkg::MODE_BEGIN_HOP);
			command(plsc_pkg::MODE_FIN_UNLOAD);
			command(plsc_pkg::MODE_UNLOAD);
			command(plsc_pkg::MODE_EOF);
			command(plsc_pkg::MODE_HELLO);
			command(plsc_pkg::MODE_EOF);
		end else begin
			command(plsc_pkg::MODE_BEGIN_HOP);
			command(plsc_pkg::MODE_EOF);
			command(plsc_pkg::MODE_BEGIN_HOP);
			command(plsc_pkg::MODE_FINISH_HOP);
			command(plsc_pkg::MODE_EOF);
			feed(8'($urandom));
		end
		drain();

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: plan_load_session_controller.f
+incdir+hw/rtl
hw/rtl/plsc_pkg.sv
hw/rtl/plsc_cfg.sv
hw/rtl/plsc_core.sv
hw/rtl/plsc_out_buf.sv
hw/rtl/plan_load_session_controller.sv
tb/sv/plan_load_session_checker.sv
tb/sv/tb_plan_load_session_controller.sv
